>>> hw/rtl/modexp_pkg.sv
// Package for the modular exponentiation block.
// Holds word width, counter width, register map and the sequencer state type.
// No dependencies.
package modexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = $clog2(WORD_BITS);
    localparam int ADDR_W    = 3;

    localparam logic [CNT_W-1:0]  CNT_LAST    = CNT_W'(WORD_BITS - 1);
    localparam logic              REG_MODULUS = 1'b0;
    localparam logic [WORD_BITS-1:0] MOD_RESET = WORD_BITS'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } modexp_state_t;

endpackage

>>> hw/rtl/modular_exponentiation.sv
// Modular exponentiation, left-to-right square-and-multiply.
// Depends on modexp_pkg for widths, register map and the state type.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries a base and an exponent.
//   Output stream (m_tvalid/m_tready/m_tdata) returns one result per transfer.
//   The modulus is written over the APB port at address 0 while idle.
// Operation:
//   One bit-serial modular multiplier does one bit per cycle. An item first
//   reduces the base, then for each exponent bit squares the accumulator
//   and, when the bit is set, multiplies it by the base; a zero modulus
//   gives 0 at once. One item is in work at a time.
// Reset:
//   Sequencer idles, output is empty, modulus returns to 2.
// Stall:
//   A finished result waits in the output register; the next input transfer
//   is taken meanwhile. A second result waits in the sequencer until the
//   output register frees.
module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // [31:0] base_value, [63:32] exponent
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata    // [31:0] power_result
);

    localparam int W = WORD_BITS;

    modexp_state_t   state_reg, state_next;
    logic [W-1:0]    mod_reg;
    logic            out_valid_reg, out_valid_next;
    logic [W-1:0]    out_data_reg, out_data_next;
    logic [W-1:0]    base_reg, base_next;
    logic [W-1:0]    exp_reg, exp_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic [W-1:0]    r_reg, r_next;
    logic [W-1:0]    b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] ecnt_reg, ecnt_next;

    logic            cfg_wr;
    logic            in_xfer;
    logic            out_load;

    // reduction step
    logic [W:0]      red_t;
    logic [W+1:0]    red_d;
    logic [W-1:0]    red_r;
    // multiply step
    logic [W-1:0]    mul_a;
    logic [W+1:0]    mul_t;
    logic [W+2:0]    mul_d1, mul_d2;
    logic [W-1:0]    mul_r;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS);
    assign prdata  = (paddr[2] == REG_MODULUS) ? mod_reg : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // base reduction: r = (2r + bit) mod n
    assign red_t = {r_reg, b_reg[W-1]};
    assign red_d = {1'b0, red_t} - {2'b0, mod_reg};
    assign red_r = red_d[W+1] ? red_t[W-1:0] : red_d[W-1:0];

    // modular multiply: r = (2r + bit*a) mod n, with 2r + a below 3n
    assign mul_a  = (state_reg == ST_SQUARE) ? acc_reg : base_reg;
    assign mul_t  = {1'b0, r_reg, 1'b0} + (b_reg[W-1] ? {2'b0, mul_a} : '0);
    assign mul_d1 = {1'b0, mul_t} - {3'b0, mod_reg};
    assign mul_d2 = {1'b0, mul_t} - {2'b0, mod_reg, 1'b0};
    assign mul_r  = !mul_d2[W+2] ? mul_d2[W-1:0] :
                    !mul_d1[W+2] ? mul_d1[W-1:0] : mul_t[W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        b_next         = b_reg;
        cnt_next       = cnt_reg;
        ecnt_next      = ecnt_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    exp_next  = s_tdata[63:32];
                    b_next    = s_tdata[31:0];
                    r_next    = '0;
                    cnt_next  = '0;
                    ecnt_next = '0;
                    acc_next  = (mod_reg == W'(1)) ? '0 : W'(1);
                    if (mod_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                r_next   = red_r;
                b_next   = {b_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    base_next  = red_r;
                    r_next     = '0;
                    b_next     = acc_reg;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE, ST_MULT:
            begin
                r_next   = mul_r;
                b_next   = {b_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    acc_next = mul_r;
                    r_next   = '0;
                    b_next   = mul_r;
                    if (state_reg == ST_SQUARE && exp_reg[W-1])
                    begin
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        exp_next  = {exp_reg[W-2:0], 1'b0};
                        ecnt_next = ecnt_reg + 1'b1;
                        state_next = (ecnt_reg == CNT_LAST) ? ST_DONE : ST_SQUARE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= MOD_RESET;
            cnt_reg       <= '0;
            ecnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            ecnt_reg      <= ecnt_next;
            if (cfg_wr)
            begin
                mod_reg <= pwdata[W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        acc_reg      <= acc_next;
        r_reg        <= r_next;
        b_reg        <= b_next;
    end

endmodule

>>> bench/modular_exponentiation_test.sv
// Testbench for modular_exponentiation: directed table, then random items over several moduli.
// Checked against typed results or a square-and-multiply predictor; modulus written over APB.
// Depends on modexp_pkg and the modular_exponentiation RTL.
module modular_exponentiation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import modexp_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int SETTLE_CYCLES = 2200;
    localparam int SEGMENTS      = 4;
    localparam int SEGMENT_ITEMS = 21;
    localparam int N_DIRECTED    = 23;

    localparam logic [ADDR_W-1:0] ADDR_MODULUS  = ADDR_W'(4 * REG_MODULUS);
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);

    typedef struct packed {
        logic [31:0] modulus;
        logic [31:0] base_value;
        logic [31:0] exponent;
        logic        has_expected;
        logic [31:0] power_result;
    } power_vector_t;

    // modulus, base, exponent, typed?, result
    localparam power_vector_t DIRECTED_VECTORS [N_DIRECTED] = '{
        '{32'd2,        32'd0,        32'd0,        1'b1, 32'd1},
        '{32'd2,        32'd3,        32'd1,        1'b1, 32'd1},
        '{32'd2,        32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd1},
        '{32'd2,        32'hFFFFFFFE, 32'd5,        1'b1, 32'd0},
        '{32'd1,        32'd7,        32'd0,        1'b1, 32'd0},
        '{32'd1,        32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0},
        '{32'd0,        32'd5,        32'd3,        1'b1, 32'd0},
        '{32'd0,        32'd0,        32'd0,        1'b1, 32'd0},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd7,        1'b1, 32'd0},
        '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd2,        1'b1, 32'd1},
        '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFE},
        '{32'hFFFFFFFF, 32'd0,        32'd0,        1'b1, 32'd1},
        '{32'hFFFFFFFF, 32'h12345678, 32'hFFFFFFFF, 1'b0, 32'd0},
        '{32'hFFFFFFFB, 32'h9E3779B9, 32'hFFFFFFFA, 1'b1, 32'd1},
        '{32'hFFFFFFFB, 32'd2,        32'd32,       1'b1, 32'd5},
        '{32'hFFFFFFFB, 32'hFFFFFFFB, 32'd1,        1'b1, 32'd0},
        '{32'hFFFFFFFB, 32'h80000000, 32'h80000000, 1'b0, 32'd0},
        '{32'd46341,    32'd46340,    32'd2,        1'b1, 32'd1},
        '{32'd46341,    32'hDEADBEEF, 32'h55555555, 1'b0, 32'd0},
        '{32'd46341,    32'h7FFFFFFF, 32'hAAAAAAAA, 1'b0, 32'd0},
        '{32'd3,        32'd2,        32'hFFFFFFFF, 1'b1, 32'd2},
        '{32'd3,        32'd4,        32'd0,        1'b1, 32'd1},
        '{32'd3,        32'd0,        32'hFFFFFFFF, 1'b1, 32'd0}
    };

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata  = '0;   // [31:0] base_value, [63:32] exponent
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;         // [31:0] power_result

    logic [31:0] expected_powers [$];
    logic [31:0] oldest_power;
    logic [31:0] cur_modulus = MOD_RESET;
    int          tx_idle_pct = 12;
    int          rx_idle_pct = 64;
    int          fail_count  = 0;
    int          cycle_count = 0;

    modular_exponentiation u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_powers.size() == 0)
            begin
                $error("power_result: expected none, got %h", m_tdata);
                fail_count++;
            end
            else
            begin
                oldest_power = expected_powers.pop_front();
                if (m_tdata !== oldest_power)
                begin
                    $error("power_result: expected %h, got %h", oldest_power, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // 64-bit products never overflow for 32-bit residues
    function automatic logic [31:0] predict_power(input logic [31:0] n,
                                                  input logic [31:0] base_value,
                                                  input logic [31:0] exponent);
        longint unsigned m;
        longint unsigned b;
        longint unsigned acc;
        if (n == 0)
            return '0;
        m   = n;
        b   = base_value % m;
        acc = 1 % m;
        for (int i = 31; i >= 0; i--)
        begin
            acc = (acc * acc) % m;
            if (exponent[i])
                acc = (acc * b) % m;
        end
        return acc[31:0];
    endfunction

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(0, 9))
            0:       return 32'hFFFFFFFF;
            1:       return 32'($urandom_range(2, 255));
            2:       return 32'($urandom_range(0, 1));
            3:       return 32'h80000000 | $urandom;
            4:       return 32'($urandom_range(46341, 65536));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_base(input logic [31:0] n);
        case ($urandom_range(0, 7))
            0:       return n - 1;
            1:       return 32'($urandom_range(0, 3));
            2:       return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'($urandom_range(1, 16));
            2:       return 32'hFFFFFFFF;
            3:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [31:0] base_value, input logic [31:0] exponent,
                             input logic has_expected, input logic [31:0] typed_result);
        logic [31:0] expected;
        expected = has_expected ? typed_result
                                : predict_power(cur_modulus, base_value, exponent);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct / 3)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, SETTLE_CYCLES)) @(posedge clk);
        end
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {exponent, base_value};
        do @(posedge clk); while (!s_tready);
        expected_powers.push_back(expected);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_powers.size() != 0);
    endtask

    task automatic apb_transfer(input logic write, input logic [ADDR_W-1:0] addr,
                                input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic check_modulus_readback();
        logic [31:0] rdata;
        apb_transfer(1'b0, ADDR_MODULUS, '0, rdata);
        if (rdata !== cur_modulus)
        begin
            $error("modulus: expected %h, got %h", cur_modulus, rdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_modulus(input logic [31:0] value);
        logic [31:0] unused;
        drain_results();
        apb_transfer(1'b1, ADDR_MODULUS, value, unused);
        cur_modulus = value;
        check_modulus_readback();
    endtask

    initial
    begin
        logic [31:0] unused;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_VECTORS[i])
        begin
            if (DIRECTED_VECTORS[i].modulus != cur_modulus)
                set_modulus(DIRECTED_VECTORS[i].modulus);
            send_item(DIRECTED_VECTORS[i].base_value, DIRECTED_VECTORS[i].exponent,
                      DIRECTED_VECTORS[i].has_expected, DIRECTED_VECTORS[i].power_result);
        end

        // write to an unmapped register must leave the modulus alone
        drain_results();
        apb_transfer(1'b1, ADDR_UNMAPPED, 32'd7, unused);
        check_modulus_readback();
        send_item(32'd5, 32'd3, 1'b0, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 12; rx_idle_pct = 64; end
                1:       begin tx_idle_pct = 64; rx_idle_pct = 12; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                set_modulus(pick_modulus());
                for (int k = 0; k < SEGMENT_ITEMS; k++)
                    send_item(pick_base(cur_modulus), pick_exponent(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
